[sv/lfkv_pkg.sv]
// ----------------------------------------------------------------------------
// lfkv_pkg
// Shared types, constants and helpers for leg forward kinematics / velocity.
// ----------------------------------------------------------------------------
package lfkv_pkg;

   localparam int NUM_COEFFS_DEF = 8;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int NUM_REGS       = 8;
   localparam int CSR_IDX_W      = $clog2(NUM_REGS);

   // register index i holds the coefficient of theta^(NUM_REGS-1-i)
   localparam logic signed [31:0] COEF_RESET [NUM_REGS] = '{
      -32'sd117092, 32'sd1920586, -32'sd12157893, 32'sd37410781,
      -32'sd60343115, 32'sd51801219, 32'sd4956489, 32'sd22228351
   };

   localparam logic signed [31:0] TURN_SCALE  = 32'sd683565276;
   localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0]        ONE_Q30     = 31'd1 << 30;
   localparam logic signed [63:0] RND_30      = 64'sd1 <<< 29;

   // series divisors, lane 0 = sine, lane 1 = cosine
   localparam int SER_STEPS = 4;
   localparam int RCP_SHIFT = 31;
   localparam longint unsigned RCP_NUM = 64'd1 << RCP_SHIFT;
   localparam logic [6:0] SER_DIV [2][SER_STEPS] = '{
      '{7'd72, 7'd42, 7'd20, 7'd6},
      '{7'd90, 7'd56, 7'd30, 7'd12}
   };
   localparam logic [28:0] SER_RCP [2][SER_STEPS] = '{
      '{29'(RCP_NUM / 72), 29'(RCP_NUM / 42), 29'(RCP_NUM / 20), 29'(RCP_NUM / 6)},
      '{29'(RCP_NUM / 90), 29'(RCP_NUM / 56), 29'(RCP_NUM / 30), 29'(RCP_NUM / 12)}
   };

   typedef struct packed {
      logic signed [31:0] leg_angle;
      logic signed [31:0] leg_rotation;
      logic signed [31:0] leg_angle_rate;
      logic signed [31:0] leg_rotation_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] foot_x;
      logic signed [31:0] foot_y;
      logic signed [31:0] foot_vel_x;
      logic signed [31:0] foot_vel_y;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [1:0] quad;
      logic       swap;
   } sc_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [71:0] v);
      return (v > 72'sd2147483647) || (v < -72'sd2147483648);
   endfunction

   // reciprocal estimate is exact or one low; one fix-up step
   function automatic logic [30:0] divfix(input logic [30:0] n, input logic [28:0] q0,
                                          input logic [6:0] d);
      logic [37:0] r;
      r = 38'(n) - 38'(q0) * 38'(d);
      if (r >= 38'(d)) begin
         return 31'(q0) + 31'd1;
      end
      return 31'(q0);
   endfunction

endpackage

[sv/leg_forward_kinematics_velocity_top.sv]
// ----------------------------------------------------------------------------
// leg_forward_kinematics_velocity_top
// Foot position and velocity from leg angle, rotation and their rates.
//
//   channel  ports                                   handshake
//   input    start, busy, req_data                   start & !busy
//   result   rsp_valid, rsp_data                     strobe, one cycle
//   config   csr_valid, csr_ready, csr_index/data    valid & ready
//
// One beat per cycle; every accepted beat yields exactly one result.
// Latency is set by the sine/cosine series chain (one multiply per stage).
// busy and csr_ready follow reset; reset loads the default coefficients and
// clears the valids, no datapath register is reset.
// The receiver cannot stall, so the pipeline advances every cycle.
// Coefficients must be written only while no beat is in flight; not enforced.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_velocity_top
   import lfkv_pkg::*;
#(
   parameter int NUM_COEFFS = NUM_COEFFS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int DEG = NUM_COEFFS - 1;
   localparam int PD  = 20 - 2 * DEG;
   localparam int LAT = 25;
   localparam logic signed [63:0] RND_F   = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] RND_F66 = 66'sd1 <<< (FRAC_BITS - 1);

   logic signed [31:0] coef_ff [NUM_REGS];
   logic [LAT:1]       vld_ff;

   assign busy      = reset;
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_valid && csr_ready) begin
         coef_ff[csr_index] <= signed'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start & ~busy};
      end
   end

   // ---------------- input capture (stage 1)
   logic signed [31:0] thl_ff  [1:DEG];
   logic signed [31:0] acc_ff  [0:DEG];
   logic signed [31:0] dacc_ff [0:DEG];
   logic               flc_ff  [0:DEG];
   logic signed [31:0] be_ff;
   logic signed [31:0] thd_ff  [1:23];
   logic signed [31:0] bed_ff  [1:23];
   logic signed [35:0] dk0;

   assign dk0 = 36'(coef_ff[NUM_REGS-1-DEG]) * 36'(DEG);

   always_ff @(posedge clock) begin
      thl_ff[1]  <= req_data.leg_angle;
      be_ff      <= req_data.leg_rotation;
      thd_ff[1]  <= req_data.leg_angle_rate;
      bed_ff[1]  <= req_data.leg_rotation_rate;
      acc_ff[0]  <= coef_ff[NUM_REGS-1-DEG];
      dacc_ff[0] <= sat32(72'(dk0));
      flc_ff[0]  <= ovf32(72'(dk0));
      for (int s = 2; s <= 23; s++) begin
         thd_ff[s] <= thd_ff[s-1];
         bed_ff[s] <= bed_ff[s-1];
      end
   end

   // ---------------- polynomial and derivative, two stages per step
   for (genvar j = 1; j <= DEG; j++) begin : g_step
      logic signed [63:0] pm_ff;
      logic signed [31:0] thm_ff;
      logic               flm_ff;
      logic signed [71:0] psum;

      assign psum = 72'((pm_ff + RND_F) >>> FRAC_BITS) + 72'(coef_ff[NUM_REGS-1-(DEG-j)]);

      always_ff @(posedge clock) begin
         pm_ff     <= acc_ff[j-1] * thl_ff[j];
         thm_ff    <= thl_ff[j];
         flm_ff    <= flc_ff[j-1];
         acc_ff[j] <= sat32(psum);
      end

      if (j < DEG) begin : g_der
         logic signed [63:0] dm_ff;
         logic signed [35:0] kc;
         logic signed [71:0] dsum;

         assign kc   = 36'(coef_ff[NUM_REGS-1-(DEG-j)]) * 36'(DEG - j);
         assign dsum = 72'((dm_ff + RND_F) >>> FRAC_BITS) + 72'(kc);

         always_ff @(posedge clock) begin
            dm_ff       <= dacc_ff[j-1] * thl_ff[j];
            dacc_ff[j]  <= sat32(dsum);
            flc_ff[j]   <= flm_ff | ovf32(psum) | ovf32(dsum);
            thl_ff[j+1] <= thm_ff;
         end
      end else begin : g_last
         logic signed [31:0] dp_ff;

         always_ff @(posedge clock) begin
            dp_ff      <= dacc_ff[j-1];
            dacc_ff[j] <= dp_ff;
            flc_ff[j]  <= flm_ff | ovf32(psum);
         end
      end
   end

   logic signed [31:0] len_dl_ff [1:PD];
   logic signed [31:0] dln_dl_ff [1:PD];
   logic               fl_dl_ff  [1:PD];

   always_ff @(posedge clock) begin
      len_dl_ff[1] <= acc_ff[DEG];
      dln_dl_ff[1] <= dacc_ff[DEG];
      fl_dl_ff[1]  <= flc_ff[DEG];
      for (int s = 2; s <= PD; s++) begin
         len_dl_ff[s] <= len_dl_ff[s-1];
         dln_dl_ff[s] <= dln_dl_ff[s-1];
         fl_dl_ff[s]  <= fl_dl_ff[s-1];
      end
   end

   // ---------------- sine / cosine of beta
   logic signed [63:0] ph_ff;
   logic [31:0]        ph;
   logic [29:0]        g_ff;
   sc_ctl_type         qs_ff [3:20];
   logic [60:0]        gx_ff;
   logic [60:0]        gx_rnd;
   logic [29:0]        x_ff  [5:18];
   logic [59:0]        xx_ff;
   logic [59:0]        xx_rnd;
   logic [29:0]        x2_ff [7:18];
   logic [30:0]        sc_ff [2];

   assign ph     = ph_ff[FRAC_BITS+31:FRAC_BITS];
   assign gx_rnd = gx_ff + 61'(ONE_Q30 >> 1);
   assign xx_rnd = xx_ff + 60'(ONE_Q30 >> 1);

   always_ff @(posedge clock) begin
      ph_ff       <= be_ff * TURN_SCALE;
      g_ff        <= ph[29] ? 30'(ONE_Q30 - 31'(ph[29:0])) : ph[29:0];
      qs_ff[3]    <= '{quad: ph[31:30], swap: ph[29]};
      gx_ff       <= g_ff * HALF_PI_Q30;
      x_ff[5]     <= gx_rnd[59:30];
      xx_ff       <= x_ff[5] * x_ff[5];
      x2_ff[7]    <= xx_rnd[59:30];
      for (int s = 4; s <= 20; s++) begin
         qs_ff[s] <= qs_ff[s-1];
      end
      for (int s = 6; s <= 18; s++) begin
         x_ff[s] <= x_ff[s-1];
      end
      for (int s = 8; s <= 18; s++) begin
         x2_ff[s] <= x2_ff[s-1];
      end
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [58:0] dm0_ff;
      logic [30:0] t_ff [SER_STEPS];
      logic [61:0] fp_ff;
      logic [61:0] fp_rnd;
      logic [30:0] r;

      assign fp_rnd = fp_ff + 62'(ONE_Q30 >> 1);
      assign r      = fp_rnd[60:30];

      always_ff @(posedge clock) begin
         dm0_ff  <= x2_ff[7] * SER_RCP[ln][0];
         t_ff[0] <= ONE_Q30 - divfix(31'(x2_ff[8]), 29'(dm0_ff >> RCP_SHIFT), SER_DIV[ln][0]);
      end

      for (genvar i = 1; i < SER_STEPS; i++) begin : g_ser
         logic [60:0] u_ff;
         logic [60:0] u_rnd;
         logic [30:0] n_ff;
         logic [59:0] qm_ff;

         assign u_rnd = u_ff + 61'(ONE_Q30 >> 1);

         always_ff @(posedge clock) begin
            u_ff    <= x2_ff[3*i+6] * t_ff[i-1];
            n_ff    <= u_rnd[60:30];
            qm_ff   <= u_rnd[60:30] * SER_RCP[ln][i];
            t_ff[i] <= ONE_Q30 - divfix(n_ff, 29'(qm_ff >> RCP_SHIFT), SER_DIV[ln][i]);
         end
      end

      if (ln == 0) begin : g_sin
         always_ff @(posedge clock) begin
            fp_ff     <= x_ff[18] * t_ff[SER_STEPS-1];
            sc_ff[ln] <= r;
         end
      end else begin : g_cos
         always_ff @(posedge clock) begin
            fp_ff     <= x2_ff[18] * t_ff[SER_STEPS-1];
            sc_ff[ln] <= ONE_Q30 - (r >> 1);
         end
      end
   end

   logic signed [31:0] sn_ff, cs_ff;
   logic signed [31:0] sv, cv;

   assign sv = signed'(32'(qs_ff[20].swap ? sc_ff[1] : sc_ff[0]));
   assign cv = signed'(32'(qs_ff[20].swap ? sc_ff[0] : sc_ff[1]));

   always_ff @(posedge clock) begin
      unique case (qs_ff[20].quad)
         2'd0: begin
            sn_ff <= sv;
            cs_ff <= cv;
         end
         2'd1: begin
            sn_ff <= cv;
            cs_ff <= -sv;
         end
         2'd2: begin
            sn_ff <= -sv;
            cs_ff <= -cv;
         end
         default: begin
            sn_ff <= -cv;
            cs_ff <= sv;
         end
      endcase
   end

   // ---------------- position and velocity (stages 22..25)
   logic signed [63:0] pls_ff, plc_ff, pds_ff, pdc_ff;
   logic signed [33:0] a_ff, b_ff, c_ff, e_ff;
   logic signed [33:0] a_w, b_w, c_w, e_w;
   logic signed [65:0] ma_ff, mb_ff, mc_ff, me_ff;
   logic signed [31:0] px_ff [23:24];
   logic signed [31:0] py_ff [23:24];
   logic               fl_ff [22:24];
   logic signed [71:0] vx_w, vy_w;
   rsp_type            rsp_ff;

   assign a_w  = 34'((pds_ff + RND_30) >>> 30);
   assign b_w  = 34'((plc_ff + RND_30) >>> 30);
   assign c_w  = 34'((pdc_ff + RND_30) >>> 30);
   assign e_w  = 34'((pls_ff + RND_30) >>> 30);
   assign vx_w = -72'((ma_ff + RND_F66) >>> FRAC_BITS) - 72'((mb_ff + RND_F66) >>> FRAC_BITS);
   assign vy_w = -72'((mc_ff + RND_F66) >>> FRAC_BITS) + 72'((me_ff + RND_F66) >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      pls_ff    <= len_dl_ff[PD] * sn_ff;
      plc_ff    <= len_dl_ff[PD] * cs_ff;
      pds_ff    <= dln_dl_ff[PD] * sn_ff;
      pdc_ff    <= dln_dl_ff[PD] * cs_ff;
      fl_ff[22] <= fl_dl_ff[PD];

      a_ff      <= a_w;
      b_ff      <= b_w;
      c_ff      <= c_w;
      e_ff      <= e_w;
      px_ff[23] <= sat32(-72'(e_w));
      py_ff[23] <= sat32(-72'(b_w));
      fl_ff[23] <= fl_ff[22] | ovf32(-72'(e_w)) | ovf32(-72'(b_w));

      ma_ff     <= a_ff * thd_ff[23];
      mb_ff     <= b_ff * bed_ff[23];
      mc_ff     <= c_ff * thd_ff[23];
      me_ff     <= e_ff * bed_ff[23];
      px_ff[24] <= px_ff[23];
      py_ff[24] <= py_ff[23];
      fl_ff[24] <= fl_ff[23];

      rsp_ff.foot_x     <= px_ff[24];
      rsp_ff.foot_y     <= py_ff[24];
      rsp_ff.foot_vel_x <= sat32(vx_w);
      rsp_ff.foot_vel_y <= sat32(vy_w);
      rsp_ff.saturated  <= fl_ff[24] | ovf32(vx_w) | ovf32(vy_w);
   end

   assign rsp_valid = vld_ff[LAT];
   assign rsp_data  = rsp_ff;

   // ---------------- checks
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat produced no result");

   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching input beat");

   a_fold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (g_ff <= 30'(ONE_Q30 >> 1)))
      else $error("folded phase beyond an eighth turn");

   a_sc_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[20] |-> (sc_ff[0] <= ONE_Q30 && sc_ff[1] <= ONE_Q30))
      else $error("sine or cosine above one");

endmodule

[dv/leg_forward_kinematics_velocity_top_test.sv]
// ----------------------------------------------------------------------------
// leg_forward_kinematics_velocity_top_test
// Self-checking bench: directed joint states followed by random bursts
// over several coefficient sets, compared against a bit-exact predictor.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_velocity_top_test;
   import lfkv_pkg::*;

   localparam int LATENCY_WAIT = 40;
   localparam int PHASE_BEATS  = 225;

   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   longint  coef_by_pow [NUM_REGS];
   rsp_type foot_queue [$];
   int      errors = 0;
   row_type rows [$];

   leg_forward_kinematics_velocity_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5000000;
      $display("leg_forward_kinematics_velocity_top_test: FAIL");
      $finish;
   end

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
         hit = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         hit = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint unsigned umul_q30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint unsigned sine_series(longint unsigned x);
      longint unsigned x2, t;
      x2 = umul_q30(x, x);
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - umul_q30(x2, t) / 42;
      t = (64'd1 << 30) - umul_q30(x2, t) / 20;
      t = (64'd1 << 30) - umul_q30(x2, t) / 6;
      return umul_q30(x, t);
   endfunction

   function automatic longint unsigned cosine_series(longint unsigned x);
      longint unsigned x2, t;
      x2 = umul_q30(x, x);
      t = (64'd1 << 30) - x2 / 90;
      t = (64'd1 << 30) - umul_q30(x2, t) / 56;
      t = (64'd1 << 30) - umul_q30(x2, t) / 30;
      t = (64'd1 << 30) - umul_q30(x2, t) / 12;
      return (64'd1 << 30) - umul_q30(x2, t) / 2;
   endfunction

   function automatic rsp_type foot_state(req_type r);
      rsp_type o;
      bit hit;
      longint th, be, thd, bed, len, dlen, sn, cs, s, c, prod, a, b, cc, e;
      longint unsigned f, g, x;
      logic [31:0] ph;
      int d;
      hit = 1'b0;
      d = NUM_COEFFS_DEF - 1;
      th = r.leg_angle;
      be = r.leg_rotation;
      thd = r.leg_angle_rate;
      bed = r.leg_rotation_rate;
      len = coef_by_pow[d];
      for (int k = d - 1; k >= 0; k--) begin
         len = clamp32(round_shift(len * th, FRAC_BITS_DEF) + coef_by_pow[k], hit);
      end
      dlen = clamp32(d * coef_by_pow[d], hit);
      for (int k = d - 1; k >= 1; k--) begin
         dlen = clamp32(round_shift(dlen * th, FRAC_BITS_DEF) + k * coef_by_pow[k], hit);
      end
      prod = be * 64'sd683565276;
      ph = prod[FRAC_BITS_DEF+31:FRAC_BITS_DEF];
      f = ph[29:0];
      if (f < (64'd1 << 29)) begin
         x = (f * 64'd1686629713 + (64'd1 << 29)) >> 30;
         s = sine_series(x);
         c = cosine_series(x);
      end else begin
         g = (64'd1 << 30) - f;
         x = (g * 64'd1686629713 + (64'd1 << 29)) >> 30;
         s = cosine_series(x);
         c = sine_series(x);
      end
      case (ph[31:30])
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
      o.foot_x = 32'(clamp32(-round_shift(len * sn, 30), hit));
      o.foot_y = 32'(clamp32(-round_shift(len * cs, 30), hit));
      a = round_shift(dlen * sn, 30);
      b = round_shift(len * cs, 30);
      cc = round_shift(dlen * cs, 30);
      e = round_shift(len * sn, 30);
      o.foot_vel_x = 32'(clamp32(-round_shift(a * thd, FRAC_BITS_DEF)
                                 - round_shift(b * bed, FRAC_BITS_DEF), hit));
      o.foot_vel_y = 32'(clamp32(-round_shift(cc * thd, FRAC_BITS_DEF)
                                 + round_shift(e * bed, FRAC_BITS_DEF), hit));
      o.saturated = hit;
      return o;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (foot_queue.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            rsp_type w;
            w = foot_queue.pop_front();
            check_field("foot_x", w.foot_x, rsp_data.foot_x);
            check_field("foot_y", w.foot_y, rsp_data.foot_y);
            check_field("foot_vel_x", w.foot_vel_x, rsp_data.foot_vel_x);
            check_field("foot_vel_y", w.foot_vel_y, rsp_data.foot_vel_y);
            check_field("saturated", w.saturated, rsp_data.saturated);
         end
      end
   end

   function automatic logic [31:0] pick_value(bit narrow);
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3, 4: return $urandom();
         default: return narrow ? 32'($urandom_range(0, 32'h3000_0000)) : $urandom();
      endcase
   endfunction

   // gap_len 0 keeps start high into the next beat
   task automatic send_beat(req_type r, bit typed, rsp_type want, int gap_len);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock iff !busy);
      foot_queue.insert(foot_queue.size(), typed ? want : foot_state(r));
      if (gap_len > 0) begin
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   task automatic write_coef(int idx, logic [31:0] value);
      repeat ($urandom_range(1, 2)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= value;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
      coef_by_pow[NUM_REGS - 1 - idx] = longint'(signed'(value));
   endtask

   task automatic drain;
      start <= 1'b0;
      wait (foot_queue.size() == 0);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic add_row(logic [31:0] th, logic [31:0] be, logic [31:0] thd,
                          logic [31:0] bed, bit typed, rsp_type want);
      row_type rw;
      rw.stim = '{th, be, thd, bed};
      rw.typed = typed;
      rw.want = want;
      rows.insert(rows.size(), rw);
   endtask

   initial begin
      int burst, gap;
      req_type r;
      for (int i = 0; i < NUM_REGS; i++) begin
         coef_by_pow[NUM_REGS - 1 - i] = COEF_RESET[i];
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // leg straight down: length is the constant term
      add_row(0, 0, 0, 0, 1, '{32'sd0, -32'sd22228351, 32'sd0, 32'sd0, 1'b0});
      // angle rate of 1 rad/s at theta zero gives minus the raw linear term
      add_row(0, 0, 32'h1000_0000, 0, 1, '{32'sd0, -32'sd22228351, 32'sd0,
              -32'sd4956489, 1'b0});
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0);
      add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0);
      add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0);
      add_row(32'h2000_0000, 32'h1921_fb54, 32'h0100_0000, 32'h0100_0000, 0, '0);
      add_row(32'h2000_0000, 32'h3243_f6a9, 32'hff00_0000, 32'h0200_0000, 0, '0);
      add_row(32'h1000_0000, 32'h4b65_f1fe, 32'h0080_0000, 32'hfe00_0000, 0, '0);
      add_row(32'h2800_0000, 32'hcdbc_0957, 32'h7fff_ffff, 32'h8000_0000, 0, '0);
      add_row(32'h2000_0000, 32'h0c90_fdaa, 0, 32'h7fff_ffff, 0, '0);
      add_row(32'h2000_0000, 32'h0c91_0000, 0, 0, 0, '0);
      add_row(32'h7000_0000, 0, 32'h1000_0000, 0, 0, '0);
      add_row(32'h9000_0000, 32'h6487_ed51, 32'h1000_0000, 32'h1000_0000, 0, '0);
      add_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, '0);
      foreach (rows[i]) begin
         send_beat(rows[i].stim, rows[i].typed, rows[i].want, $urandom_range(0, 2));
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            case (phase)
               0: write_coef(i, 32'h7fff_ffff);
               1: write_coef(i, 32'h8000_0000);
               2: write_coef(i, $urandom());
               3: write_coef(i, 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000));
               4: write_coef(i, COEF_RESET[i]);
               default: write_coef(i, $urandom_range(0, 1) ? $urandom() : COEF_RESET[i]);
            endcase
         end
         burst = 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            r.leg_angle = pick_value(1);
            r.leg_rotation = pick_value(0);
            r.leg_angle_rate = pick_value(0);
            r.leg_rotation_rate = pick_value(0);
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
            end
            burst--;
            gap = (burst == 0) ? $urandom_range(1, 6) : 0;
            send_beat(r, 0, '0, gap);
         end
         drain();
      end

      if (errors == 0) begin
         $display("leg_forward_kinematics_velocity_top_test: PASS");
      end else begin
         $display("leg_forward_kinematics_velocity_top_test: FAIL");
      end
      $finish;
   end

endmodule
